>>> hw/rtl/hilbert_curve_move_generator_defines.svh
// ----------------------------------------------------------------------------
// hilbert curve move generator assertion macros
// shared concurrent assertion forms, clocked on clock, held off during reset
// ----------------------------------------------------------------------------
`ifndef HILBERT_CURVE_MOVE_GENERATOR_DEFINES_SVH
`define HILBERT_CURVE_MOVE_GENERATOR_DEFINES_SVH

// same-cycle implication
`define HCMG_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HCMG_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/hcmg_pkg.sv
// ----------------------------------------------------------------------------
// hcmg_pkg
// shared types, constants and microcode for the hilbert curve move generator
// ----------------------------------------------------------------------------
package hcmg_pkg;

   // deepest recursion the stack holds
   localparam int MAX_ORDER = 8;
   localparam int LVL_W     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int RUN_W     = $clog2(MAX_ORDER + 1);

   // register and field widths
   localparam int CURVE_ORDER_W = 4;
   localparam int TURN_ANGLE_W  = 9;
   localparam int STEP_LENGTH_W = 10;
   localparam int CSR_DATA_W    = 10;
   localparam int CSR_INDEX_W   = 2;
   localparam int AMOUNT_W      = 11;
   localparam int PHASE_W       = 4;
   localparam int CMP_W         = ((RUN_W > CURVE_ORDER_W) ? RUN_W : CURVE_ORDER_W) + 1;

   // register reset values
   localparam logic [CURVE_ORDER_W-1:0] CURVE_ORDER_RST = CURVE_ORDER_W'(5);
   localparam logic [TURN_ANGLE_W-1:0]  TURN_ANGLE_RST  = TURN_ANGLE_W'(90);
   localparam logic [STEP_LENGTH_W-1:0] STEP_LENGTH_RST = STEP_LENGTH_W'(10);

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CURVE_ORDER = 2'd0,
      CSR_TURN_ANGLE  = 2'd1,
      CSR_STEP_LENGTH = 2'd2
   } csr_index_type;

   // per-level phases of the recursion
   localparam logic [PHASE_W-1:0] PH_RIGHT_HEAD = 4'd0;
   localparam logic [PHASE_W-1:0] PH_SUB_A      = 4'd1;
   localparam logic [PHASE_W-1:0] PH_LEFT_A     = 4'd3;
   localparam logic [PHASE_W-1:0] PH_SUB_B      = 4'd4;
   localparam logic [PHASE_W-1:0] PH_SUB_C      = 4'd6;
   localparam logic [PHASE_W-1:0] PH_LEFT_B     = 4'd7;
   localparam logic [PHASE_W-1:0] PH_SUB_D      = 4'd9;
   localparam logic [PHASE_W-1:0] PH_RIGHT_TAIL = 4'd10;
   localparam logic [PHASE_W-1:0] PH_DONE       = 4'd11;

   typedef enum logic [1:0] {
      KIND_RIGHT = 2'd0,
      KIND_LEFT  = 2'd1,
      KIND_FWD   = 2'd2
   } move_kind_type;

   // microcode addresses
   typedef enum logic [1:0] {
      STEP_FETCH = 2'd0,
      STEP_CHECK = 2'd1,
      STEP_INIT  = 2'd2,
      STEP_WALK  = 2'd3
   } step_type;

   // jump conditions
   typedef enum logic [1:0] {
      COND_NEVER      = 2'd0,
      COND_RESTART    = 2'd1,
      COND_IDLE       = 2'd2,
      COND_ORDER_ZERO = 2'd3
   } cond_type;

   // one control word
   typedef struct packed {
      logic     take_req;
      logic     init_stack;
      logic     walk;
      cond_type cond;
      step_type jump;
      step_type next;
   } cw_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic req_valid;
      logic restart;
      logic running;
      logic order_zero;
      logic walk_done;
   } seq_status_type;

   // microcode program
   function automatic cw_type ucode_word(input step_type pc);
      cw_type w;
      w = '{take_req: 1'b0, init_stack: 1'b0, walk: 1'b0, cond: COND_NEVER,
            jump: STEP_FETCH, next: STEP_FETCH};
      case (pc)
         STEP_FETCH: begin
            w.take_req = 1'b1;
            w.cond     = COND_RESTART;
            w.jump     = STEP_INIT;
            w.next     = STEP_CHECK;
         end
         STEP_CHECK: begin
            w.cond = COND_IDLE;
            w.jump = STEP_FETCH;
            w.next = STEP_WALK;
         end
         STEP_INIT: begin
            w.init_stack = 1'b1;
            w.cond       = COND_ORDER_ZERO;
            w.jump       = STEP_FETCH;
            w.next       = STEP_WALK;
         end
         STEP_WALK: begin
            w.walk = 1'b1;
            w.next = STEP_FETCH;
         end
         default: begin
            w.next = STEP_FETCH;
         end
      endcase
      return w;
   endfunction

endpackage

>>> hw/rtl/hcmg_seq.sv
// ----------------------------------------------------------------------------
// hcmg_seq
// microcode sequencer: step counter, program rom and conditional jumps
// ----------------------------------------------------------------------------
module hcmg_seq import hcmg_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  seq_status_type status,
   output cw_type         cw
);

   step_type pc_ff;
   step_type pc_in;
   logic     stall;
   logic     cond_hit;

   // control word for the current step
   assign cw = ucode_word(pc_ff);

   // hold, jump or advance
   always_comb begin
      stall = (cw.take_req && !status.req_valid) || (cw.walk && !status.walk_done);
      case (cw.cond)
         COND_NEVER:      cond_hit = 1'b0;
         COND_RESTART:    cond_hit = status.restart;
         COND_IDLE:       cond_hit = !status.running;
         COND_ORDER_ZERO: cond_hit = status.order_zero;
         default:         cond_hit = 1'b0;
      endcase
      if (stall) begin
         pc_in = pc_ff;
      end else if (cond_hit) begin
         pc_in = cw.jump;
      end else begin
         pc_in = cw.next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

>>> hw/rtl/hilbert_curve_move_generator.sv
// ----------------------------------------------------------------------------
// hilbert_curve_move_generator
// turtle move generator for a hilbert curve with an explicit recursion stack
// ----------------------------------------------------------------------------
// Each request beat asks for one move (restart starts a new curve) and gets at
// most one response beat. A small microcode program runs the work: a fetch
// step takes the beat, a check step dispatches (or an init step loads the
// stack on restart), then walk steps run until a move comes out. Every push,
// pop or skipped sub-curve lands on a move phase, so at most one such walk
// step comes before the move, besides any walk steps that wait for the
// output register to free up. A request that gives no move returns to the
// fetch step from the check or init step. The finished move sits in
// an output register, so the next request is taken while it waits.
// curve_order is sampled at restart; turn_angle and step_length are read on
// every move. After the move marked last, requests without restart give no
// response.
// ----------------------------------------------------------------------------
`include "hilbert_curve_move_generator_defines.svh"

module hilbert_curve_move_generator import hcmg_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_restart,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_move_kind,
   output logic signed [AMOUNT_W-1:0]  rsp_move_amount,
   output logic                        rsp_last,
   // register write port
   input  logic                        csr_write_en,
   input  logic [CSR_INDEX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata
);

   // registers
   logic [CURVE_ORDER_W-1:0] curve_order_ff;
   logic [TURN_ANGLE_W-1:0]  turn_angle_ff;
   logic [STEP_LENGTH_W-1:0] step_length_ff;

   // recursion stack and run state
   logic [PHASE_W-1:0]   phase_ff [MAX_ORDER];
   logic [PHASE_W-1:0]   phase_in [MAX_ORDER];
   logic [MAX_ORDER-1:0] sign_ff;
   logic [MAX_ORDER-1:0] sign_in;
   logic [LVL_W-1:0]     level_ff;
   logic [LVL_W-1:0]     level_in;
   logic [RUN_W-1:0]     run_order_ff;
   logic [RUN_W-1:0]     run_order_in;
   logic                 running_ff;
   logic                 running_in;

   // output register
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   move_kind_type              rsp_move_kind_ff;
   logic signed [AMOUNT_W-1:0] rsp_move_amount_ff;
   logic                       rsp_last_ff;

   // sequencer link
   cw_type         cw;
   seq_status_type status;

   // walk datapath
   logic [PHASE_W-1:0]         cur_phase;
   logic                       cur_sign;
   logic [LVL_W-1:0]           level_up;
   logic [CMP_W-1:0]           level_ext;
   logic [CMP_W-1:0]           level_up_ext;
   logic [CMP_W-1:0]           run_ext;
   logic [CMP_W-1:0]           order_ext;
   logic [CMP_W-1:0]           sat_order;
   logic [AMOUNT_W-1:0]        angle_ext;
   logic signed [AMOUNT_W-1:0] angle_signed;
   logic                       out_free;
   logic                       emit;
   logic                       stop;
   move_kind_type              emit_kind;
   logic signed [AMOUNT_W-1:0] emit_amount;
   logic                       emit_last;

   hcmg_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cw     (cw)
   );

   // handshake
   assign req_ready = cw.take_req;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // operand shaping
   always_comb begin
      cur_phase    = phase_ff[level_ff];
      cur_sign     = sign_ff[level_ff];
      level_up     = level_ff + 1'b1;
      level_ext    = CMP_W'(level_ff);
      level_up_ext = level_ext + 1'b1;
      run_ext      = CMP_W'(run_order_ff);
      order_ext    = CMP_W'(curve_order_ff);
      sat_order    = (order_ext > CMP_W'(MAX_ORDER)) ? CMP_W'(MAX_ORDER) : order_ext;
      angle_ext    = AMOUNT_W'(turn_angle_ff);
      angle_signed = cur_sign ? -$signed(angle_ext) : $signed(angle_ext);
   end

   // one stack step per walk cycle, unless a move phase waits for the output register to free up
   always_comb begin
      phase_in     = phase_ff;
      sign_in      = sign_ff;
      level_in     = level_ff;
      run_order_in = run_order_ff;
      running_in   = running_ff;
      emit         = 1'b0;
      stop         = 1'b0;
      emit_kind    = KIND_FWD;
      emit_amount  = $signed(AMOUNT_W'(step_length_ff));
      emit_last    = 1'b0;
      if (cw.init_stack) begin
         for (int i = 0; i < MAX_ORDER; i++) begin
            phase_in[i] = '0;
         end
         sign_in      = '0;
         level_in     = '0;
         run_order_in = RUN_W'(sat_order);
         running_in   = (sat_order != '0);
      end else if (cw.walk) begin
         if (level_ext >= run_ext) begin
            // stack beyond the curve depth: nothing left to give
            stop = 1'b1;
         end else if (cur_phase >= PH_DONE) begin
            // level finished: clear it and return to the parent
            if (level_ff == '0) begin
               stop = 1'b1;
            end else begin
               phase_in[level_ff] = '0;
               level_in           = level_ff - 1'b1;
            end
         end else if (cur_phase == PH_SUB_A || cur_phase == PH_SUB_B ||
                      cur_phase == PH_SUB_C || cur_phase == PH_SUB_D) begin
            // sub-curve: descend, or skip at the innermost level
            phase_in[level_ff] = cur_phase + 1'b1;
            if (level_up_ext < run_ext) begin
               sign_in[level_up] = cur_sign ^
                  ((cur_phase == PH_SUB_A) || (cur_phase == PH_SUB_D));
               level_in          = level_up;
            end
         end else if (out_free) begin
            // move phase: produce one move
            phase_in[level_ff] = cur_phase + 1'b1;
            emit               = 1'b1;
            if (cur_phase == PH_RIGHT_HEAD || cur_phase == PH_RIGHT_TAIL) begin
               emit_kind   = KIND_RIGHT;
               emit_amount = angle_signed;
            end else if (cur_phase == PH_LEFT_A || cur_phase == PH_LEFT_B) begin
               emit_kind   = KIND_LEFT;
               emit_amount = angle_signed;
            end
            if (cur_phase == PH_RIGHT_TAIL && level_ff == '0) begin
               emit_last  = 1'b1;
               running_in = 1'b0;
            end
         end
         if (stop) begin
            running_in = 1'b0;
         end
      end
   end

   // status back to the sequencer
   always_comb begin
      status.req_valid  = req_valid;
      status.restart    = req_restart;
      status.running    = running_ff;
      status.order_zero = (sat_order == '0);
      status.walk_done  = emit || stop;
   end

   // output register next valid
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control and stack state
   always_ff @(posedge clock) begin
      if (reset) begin
         curve_order_ff <= CURVE_ORDER_RST;
         turn_angle_ff  <= TURN_ANGLE_RST;
         step_length_ff <= STEP_LENGTH_RST;
         for (int i = 0; i < MAX_ORDER; i++) begin
            phase_ff[i] <= '0;
         end
         sign_ff      <= '0;
         level_ff     <= '0;
         run_order_ff <= '0;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_CURVE_ORDER: curve_order_ff <= csr_wdata[CURVE_ORDER_W-1:0];
               CSR_TURN_ANGLE:  turn_angle_ff  <= csr_wdata[TURN_ANGLE_W-1:0];
               CSR_STEP_LENGTH: step_length_ff <= csr_wdata[STEP_LENGTH_W-1:0];
               default: begin
               end
            endcase
         end
         phase_ff     <= phase_in;
         sign_ff      <= sign_in;
         level_ff     <= level_in;
         run_order_ff <= run_order_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_move_kind_ff   <= emit_kind;
         rsp_move_amount_ff <= emit_amount;
         rsp_last_ff        <= emit_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_move_kind   = rsp_move_kind_ff;
   assign rsp_move_amount = rsp_move_amount_ff;
   assign rsp_last        = rsp_last_ff;

   // checks
   `HCMG_ASSERT_IMP(a_last_is_right_turn, rsp_valid && rsp_last, rsp_move_kind == KIND_RIGHT, "last move is not a right turn")
   `HCMG_ASSERT_IMP(a_level_in_range, running_ff, level_ext < run_ext, "stack level beyond curve order")
   `HCMG_ASSERT_NXT(a_last_ends_run, emit && emit_last, !running_ff && rsp_valid_ff, "run continues after last move")

endmodule

>>> tb/hcmg_checker.sv
// ----------------------------------------------------------------------------
// hcmg_checker
// watches the request, response and register ports of the hilbert curve move
// generator, predicts each move from its own copy of the level stack and
// compares every response beat field by field against the oldest prediction
// ----------------------------------------------------------------------------
module hcmg_checker import hcmg_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_restart,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [1:0]                  rsp_move_kind,
   input  logic signed [AMOUNT_W-1:0]  rsp_move_amount,
   input  logic                        rsp_last,
   input  logic                        csr_write_en,
   input  logic [CSR_INDEX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata,
   output int                          error_count,
   output int                          pending_count
);

   typedef struct packed {
      move_kind_type               kind;
      logic signed [AMOUNT_W-1:0]  amount;
      logic                        last;
   } turtle_move_type;

   // register shadows
   logic [CURVE_ORDER_W-1:0] cfg_order;
   logic [TURN_ANGLE_W-1:0]  cfg_angle;
   logic [STEP_LENGTH_W-1:0] cfg_step;

   // level stack of the curve walk
   logic [PHASE_W-1:0] lvl_phase [MAX_ORDER];
   logic               lvl_neg   [MAX_ORDER];
   int unsigned        lvl_top;
   int unsigned        curve_depth;
   logic               curve_active;

   turtle_move_type expected_moves [$];
   turtle_move_type want;
   turtle_move_type got;
   int              mismatches = 0;

   // advance the walk by one tick; returns 1 when a move comes out
   function automatic logic next_move(input logic restart_bit, output turtle_move_type mv);
      int unsigned        lvl;
      logic [PHASE_W-1:0] ph;
      logic               neg;
      logic [AMOUNT_W-1:0] ang;
      mv = '0;
      if (restart_bit) begin
         curve_depth = (cfg_order > MAX_ORDER) ? MAX_ORDER : cfg_order;
         for (int i = 0; i < MAX_ORDER; i++) begin
            lvl_phase[i] = '0;
            lvl_neg[i]   = 1'b0;
         end
         lvl_top      = 0;
         curve_active = (curve_depth != 0);
      end
      if (!curve_active) return 1'b0;

      for (int guard = 0; guard < 8 * MAX_ORDER + 16; guard++) begin
         lvl = lvl_top;
         if (lvl >= curve_depth) break;
         ph  = lvl_phase[lvl];
         neg = lvl_neg[lvl];

         // sub-curve finished: pop to the parent and step past its slot
         if (ph >= PH_DONE) begin
            if (lvl == 0) break;
            lvl_top = lvl - 1;
            lvl_phase[lvl-1] = lvl_phase[lvl-1] + 1'b1;
            continue;
         end

         // sub-curve slot: push a child, or skip it at the innermost level
         if (ph == PH_SUB_A || ph == PH_SUB_B || ph == PH_SUB_C || ph == PH_SUB_D) begin
            if (lvl + 1 < curve_depth) begin
               lvl_top = lvl + 1;
               lvl_phase[lvl+1] = '0;
               lvl_neg[lvl+1]   = neg ^ (ph == PH_SUB_A || ph == PH_SUB_D);
            end else begin
               lvl_phase[lvl] = ph + 1'b1;
            end
            continue;
         end

         // move slot
         ang = {2'b00, cfg_angle};
         lvl_phase[lvl] = ph + 1'b1;
         mv.amount = neg ? -ang : ang;
         if (ph == PH_RIGHT_HEAD) begin
            mv.kind = KIND_RIGHT;
         end else if (ph == PH_LEFT_A || ph == PH_LEFT_B) begin
            mv.kind = KIND_LEFT;
         end else if (ph == PH_RIGHT_TAIL) begin
            mv.kind = KIND_RIGHT;
            mv.last = (lvl == 0);
            if (lvl == 0) curve_active = 1'b0;
         end else begin
            mv.kind   = KIND_FWD;
            mv.amount = {1'b0, cfg_step};
         end
         return 1'b1;
      end

      curve_active = 1'b0;
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_order    = CURVE_ORDER_RST;
         cfg_angle    = TURN_ANGLE_RST;
         cfg_step     = STEP_LENGTH_RST;
         for (int i = 0; i < MAX_ORDER; i++) begin
            lvl_phase[i] = '0;
            lvl_neg[i]   = 1'b0;
         end
         lvl_top      = 0;
         curve_depth  = 0;
         curve_active = 1'b0;
         expected_moves.delete();
         pending_count <= 0;
      end else begin
         // response beat against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_moves.size() == 0) begin
               $error("move beat with nothing predicted: kind %0d amount %0d last %0d",
                      rsp_move_kind, rsp_move_amount, rsp_last);
               mismatches++;
            end else begin
               want = expected_moves.pop_front();
               if (rsp_move_kind !== want.kind) begin
                  $error("move_kind: expected %0d, actual %0d", want.kind, rsp_move_kind);
                  mismatches++;
               end
               if (rsp_move_amount !== want.amount) begin
                  $error("move_amount: expected %0d, actual %0d",
                         want.amount, rsp_move_amount);
                  mismatches++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_last);
                  mismatches++;
               end
            end
         end

         // register writes
         if (csr_write_en) begin
            case (csr_index)
               CSR_CURVE_ORDER: cfg_order = csr_wdata[CURVE_ORDER_W-1:0];
               CSR_TURN_ANGLE:  cfg_angle = csr_wdata[TURN_ANGLE_W-1:0];
               CSR_STEP_LENGTH: cfg_step  = csr_wdata[STEP_LENGTH_W-1:0];
               default: ;
            endcase
         end

         // request beat
         if (req_valid && req_ready) begin
            if (next_move(req_restart, got)) expected_moves.push_back(got);
         end

         pending_count <= expected_moves.size();
      end
      error_count <= mismatches;
   end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives the hilbert curve move generator with directed and random curve
// runs under changing register settings and idle patterns; hcmg_checker
// predicts and compares the moves, this module gives the verdict
// ----------------------------------------------------------------------------
module tb_top import hcmg_pkg::*; ();

   logic                        clock        = 1'b0;
   logic                        reset        = 1'b1;
   logic                        req_valid    = 1'b0;
   logic                        req_ready;
   logic                        req_restart  = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready    = 1'b0;
   logic [1:0]                  rsp_move_kind;
   logic signed [AMOUNT_W-1:0]  rsp_move_amount;
   logic                        rsp_last;
   logic                        csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0]      csr_index    = CSR_CURVE_ORDER;
   logic [CSR_DATA_W-1:0]       csr_wdata    = '0;

   int          error_count;
   int          pending_count;
   int unsigned send_idle  = 35;
   int unsigned recv_idle  = 58;
   int unsigned beats_sent = 0;

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   hilbert_curve_move_generator dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_move_kind   (rsp_move_kind),
      .rsp_move_amount (rsp_move_amount),
      .rsp_last        (rsp_last),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   hcmg_checker move_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_move_kind   (rsp_move_kind),
      .rsp_move_amount (rsp_move_amount),
      .rsp_last        (rsp_last),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .error_count     (error_count),
      .pending_count   (pending_count)
   );

   // receiver stalls
   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle);
   end

   // one request beat; valid stays high afterwards until the caller moves on
   task automatic send_beat(input logic restart_bit);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart_bit;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   // drop valid and hold off until every predicted move is out and the walk has settled
   task automatic wait_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (24) @(posedge clock);
   endtask

   // write all three registers on consecutive cycles
   task automatic set_curve_params(input logic [CURVE_ORDER_W-1:0] ord,
                                   input logic [TURN_ANGLE_W-1:0]  ang,
                                   input logic [STEP_LENGTH_W-1:0] stp);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_CURVE_ORDER;
      csr_wdata    <= CSR_DATA_W'(ord);
      @(posedge clock);
      csr_index    <= CSR_TURN_ANGLE;
      csr_wdata    <= CSR_DATA_W'(ang);
      @(posedge clock);
      csr_index    <= CSR_STEP_LENGTH;
      csr_wdata    <= CSR_DATA_W'(stp);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // one curve: mostly complete small curves, some cut short or reconfigured mid-way
   task automatic random_run();
      int unsigned pick;
      int unsigned ord;
      int unsigned moves;
      int unsigned ticks;
      int unsigned split_at;
      pick = $urandom_range(99);
      if (pick < 10)      ord = 0;
      else if (pick < 40) ord = 1;
      else if (pick < 75) ord = 2;
      else if (pick < 90) ord = 3;
      else if (pick < 95) ord = $urandom_range(4, MAX_ORDER);
      else                ord = $urandom_range(MAX_ORDER + 1, 15);

      wait_quiet();
      set_curve_params(CURVE_ORDER_W'(ord), TURN_ANGLE_W'($urandom_range(0, 511)),
                       STEP_LENGTH_W'($urandom_range(0, 1023)));

      if (ord <= 3) begin
         moves = 0;
         repeat (ord) moves = 7 + 4 * moves;
         ticks = ((moves > 0) ? moves - 1 : 0) + $urandom_range(0, 2);
      end else begin
         ticks = $urandom_range(5, 60);
      end
      if ($urandom_range(99) < 15) ticks = $urandom_range(0, ticks);
      split_at = ($urandom_range(99) < 20) ? $urandom_range(0, ticks) : ticks + 1;

      send_beat(1'b1);
      for (int i = 0; i < ticks; i++) begin
         // curve_order waits for the next restart, angle and length apply at once
         if (i == split_at) begin
            wait_quiet();
            set_curve_params(CURVE_ORDER_W'($urandom_range(0, 15)),
                             TURN_ANGLE_W'($urandom_range(0, 511)),
                             STEP_LENGTH_W'($urandom_range(0, 1023)));
         end
         send_beat($urandom_range(99) < 2);
      end
   endtask

   // run end guard
   initial begin
      #(12 * 400000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // stimulus and verdict
   initial begin
      int unsigned start;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // tick while idle, then a short run on the reset settings
      send_beat(1'b0);
      send_beat(1'b1);
      repeat (2) send_beat(1'b0);

      // empty curve: restart with order zero, then an idle tick
      wait_quiet();
      set_curve_params(CURVE_ORDER_W'(0), TURN_ANGLE_W'(90), STEP_LENGTH_W'(10));
      send_beat(1'b1);
      send_beat(1'b0);

      // full first-order curve at angle 359 and the largest length, one tick past the end
      wait_quiet();
      set_curve_params(CURVE_ORDER_W'(1), TURN_ANGLE_W'(359), STEP_LENGTH_W'(1023));
      send_beat(1'b1);
      repeat (7) send_beat(1'b0);

      // order above the stack depth saturates; zero angle and zero length
      wait_quiet();
      set_curve_params(CURVE_ORDER_W'(15), TURN_ANGLE_W'(0), STEP_LENGTH_W'(0));
      send_beat(1'b1);
      repeat (3) send_beat(1'b0);

      // new settings under a running curve, then a restart mid-curve
      wait_quiet();
      set_curve_params(CURVE_ORDER_W'(2), TURN_ANGLE_W'(1), STEP_LENGTH_W'(512));
      repeat (2) send_beat(1'b0);
      send_beat(1'b1);
      repeat (2) send_beat(1'b0);

      // random curve runs under three idle patterns
      for (int p = 0; p < 3; p++) begin
         send_idle = (p == 0) ? 35 : (p == 1) ? 58 : 0;
         recv_idle = (p == 0) ? 58 : (p == 1) ? 35 : 0;
         start = beats_sent;
         while (beats_sent - start < 250) random_run();
      end

      // drain
      req_valid <= 1'b0;
      for (int n = 0; n < 50000 && pending_count != 0; n++) @(posedge clock);
      repeat (24) @(posedge clock);

      if (error_count == 0 && pending_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/hcmg_pkg.sv
hw/rtl/hcmg_seq.sv
hw/rtl/hilbert_curve_move_generator.sv
tb/hcmg_checker.sv
tb/tb_top.sv
